@@ rtl/core/fraction_reduce_defines.svh @@
// Assertion macros for the fraction_reduce block.
// Used by fraction_reduce.sv; no other dependencies.
`ifndef FRACTION_REDUCE_DEFINES_SVH
`define FRACTION_REDUCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FR_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/core/fr_pkg.sv @@
// Package for fraction_reduce: microcode word type, action and condition codes,
// step names and the control ROM. No dependencies.
package fr_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_LOAD     = 4'd1;
  localparam logic [3:0] ACT_START_AB = 4'd2;
  localparam logic [3:0] ACT_WAIT     = 4'd3;
  localparam logic [3:0] ACT_EUC_UPD  = 4'd4;
  localparam logic [3:0] ACT_START_N  = 4'd5;
  localparam logic [3:0] ACT_UPD_N    = 4'd6;
  localparam logic [3:0] ACT_START_D  = 4'd7;
  localparam logic [3:0] ACT_UPD_D    = 4'd8;
  localparam logic [3:0] ACT_OUT      = 4'd9;

  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_IN    = 3'd2;
  localparam logic [2:0] COND_SPECIAL  = 3'd3;
  localparam logic [2:0] COND_B_ZERO   = 3'd4;
  localparam logic [2:0] COND_DIV_BUSY = 3'd5;
  localparam logic [2:0] COND_NO_OUT   = 3'd6;

  localparam step_t ST_LOAD    = 4'd0;
  localparam step_t ST_CHECK   = 4'd1;
  localparam step_t ST_TEST    = 4'd2;
  localparam step_t ST_EUC_GO  = 4'd3;
  localparam step_t ST_EUC_WT  = 4'd4;
  localparam step_t ST_EUC_UPD = 4'd5;
  localparam step_t ST_N_GO    = 4'd6;
  localparam step_t ST_N_WT    = 4'd7;
  localparam step_t ST_N_UPD   = 4'd8;
  localparam step_t ST_D_GO    = 4'd9;
  localparam step_t ST_D_WT    = 4'd10;
  localparam step_t ST_D_UPD   = 4'd11;
  localparam step_t ST_OUT     = 4'd12;
  localparam step_t ST_RET     = 4'd13;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] cond;
    step_t      target;
  } uc_word_t;

  // Condition true: go to target; else fall through to the next step.
  function automatic uc_word_t ucode(input step_t step);
    uc_word_t w;
    unique case (step)
      ST_LOAD:    w = '{ACT_LOAD,     COND_NO_IN,    ST_LOAD};
      ST_CHECK:   w = '{ACT_NONE,     COND_SPECIAL,  ST_OUT};
      ST_TEST:    w = '{ACT_NONE,     COND_B_ZERO,   ST_N_GO};
      ST_EUC_GO:  w = '{ACT_START_AB, COND_NEVER,    ST_LOAD};
      ST_EUC_WT:  w = '{ACT_WAIT,     COND_DIV_BUSY, ST_EUC_WT};
      ST_EUC_UPD: w = '{ACT_EUC_UPD,  COND_ALWAYS,   ST_TEST};
      ST_N_GO:    w = '{ACT_START_N,  COND_NEVER,    ST_LOAD};
      ST_N_WT:    w = '{ACT_WAIT,     COND_DIV_BUSY, ST_N_WT};
      ST_N_UPD:   w = '{ACT_UPD_N,    COND_NEVER,    ST_LOAD};
      ST_D_GO:    w = '{ACT_START_D,  COND_NEVER,    ST_LOAD};
      ST_D_WT:    w = '{ACT_WAIT,     COND_DIV_BUSY, ST_D_WT};
      ST_D_UPD:   w = '{ACT_UPD_D,    COND_NEVER,    ST_LOAD};
      ST_OUT:     w = '{ACT_OUT,      COND_NO_OUT,   ST_OUT};
      ST_RET:     w = '{ACT_NONE,     COND_ALWAYS,   ST_LOAD};
      default:    w = '{ACT_NONE,     COND_ALWAYS,   ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/fr_in_if.sv @@
// Input channel of fraction_reduce: valid/ready plus numerator and denominator.
// No dependencies.
interface fr_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator_in;
  logic signed [DATA_WIDTH-1:0] denominator_in;

  modport source (output valid, output numerator_in, output denominator_in, input ready);
  modport sink   (input valid, input numerator_in, input denominator_in, output ready);
endinterface

@@ rtl/core/fr_out_if.sv @@
// Result channel of fraction_reduce: valid/ready plus reduced fraction and flag.
// No dependencies.
interface fr_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator_out;
  logic        [DATA_WIDTH-2:0] denominator_out;
  logic                         invalid;

  modport source (output valid, output numerator_out, output denominator_out,
                  output invalid, input ready);
  modport sink   (input valid, input numerator_out, input denominator_out,
                  input invalid, output ready);
endinterface

@@ rtl/core/fraction_reduce.sv @@
// fraction_reduce: reduces a signed fraction to lowest terms.
// Depends on fr_pkg, fr_in_if, fr_out_if and fraction_reduce_defines.svh.
//
// Usage:
//   in_ch  : valid/ready channel carrying numerator_in and denominator_in.
//   out_ch : valid/ready channel carrying numerator_out, denominator_out and
//            invalid. One result per input transfer, in order.
//   One item is in flight at a time; in_ch.ready is high only while the
//   sequencer sits at its load step.
//   Operation: a microcoded sequencer drives a shared restoring divider that
//   retires one quotient bit per cycle, DATA_WIDTH-1 bits per division. An item
//   runs the remainder steps of Euclid's loop, then divides numerator and
//   denominator by the resulting gcd, presents the result on out_ch and
//   returns to the load step.
//   A zero denominator or a most-negative input answers invalid with 0/0,
//   going from the check step straight to the result step.
//   Reset (rst_n low, synchronous) returns the sequencer to the load step and
//   stops the divider; no result is pending afterward.
//   Receiver stall: the result holds on out_ch while out_ch.ready is low, and
//   no new input is taken until the result transfer completes.
`include "fraction_reduce_defines.svh"

module fraction_reduce #(
  parameter int DATA_WIDTH = fr_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fr_in_if.sink      in_ch,
  fr_out_if.source   out_ch
);

  localparam int M  = DATA_WIDTH - 1;
  localparam int CW = $clog2(M + 1);

  fr_pkg::step_t    step_r;
  fr_pkg::uc_word_t uc;
  logic             cond_hit;

  logic [M-1:0] a_r, b_r, n_r, d_r;
  logic         neg_r;
  logic         special_r;

  logic signed [DATA_WIDTH-1:0] on_r;
  logic        [M-1:0]          od_r;
  logic                         inv_r;

  logic          div_busy_r;
  logic [M-1:0]  div_rem_r, div_quo_r, div_den_r;
  logic [CW-1:0] div_cnt_r;
  logic [M:0]    div_shl;
  logic          div_ge;

  logic [DATA_WIDTH-1:0] n_neg, d_neg, smin;
  logic [M-1:0]          nmag, dmag;
  logic                  in_special;
  logic                  div_start;
  logic [M-1:0]          div_dvd, div_dvs;
  logic [DATA_WIDTH-1:0] n_ext;

  assign uc = fr_pkg::ucode(step_r);

  always_comb begin
    unique case (uc.cond)
      fr_pkg::COND_NEVER:    cond_hit = 1'b0;
      fr_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      fr_pkg::COND_NO_IN:    cond_hit = !in_ch.valid;
      fr_pkg::COND_SPECIAL:  cond_hit = special_r;
      fr_pkg::COND_B_ZERO:   cond_hit = (b_r == '0);
      fr_pkg::COND_DIV_BUSY: cond_hit = div_busy_r;
      fr_pkg::COND_NO_OUT:   cond_hit = !out_ch.ready;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fr_pkg::ST_LOAD;
    end else if (cond_hit) begin
      step_r <= uc.target;
    end else begin
      step_r <= step_r + fr_pkg::step_t'(1);
    end
  end

  assign in_ch.ready = rst_n && (uc.act == fr_pkg::ACT_LOAD);
  assign out_ch.valid = (uc.act == fr_pkg::ACT_OUT);
  assign out_ch.numerator_out = on_r;
  assign out_ch.denominator_out = od_r;
  assign out_ch.invalid = inv_r;

  // Input magnitudes; the most negative value is flagged separately.
  assign smin  = {1'b1, {M{1'b0}}};
  assign n_neg = -in_ch.numerator_in;
  assign d_neg = -in_ch.denominator_in;
  assign nmag  = in_ch.numerator_in[M] ? n_neg[M-1:0] : in_ch.numerator_in[M-1:0];
  assign dmag  = in_ch.denominator_in[M] ? d_neg[M-1:0] : in_ch.denominator_in[M-1:0];
  assign in_special = (in_ch.denominator_in == '0) ||
                      (in_ch.numerator_in == smin) || (in_ch.denominator_in == smin);

  assign n_ext = {1'b0, n_r};

  always_ff @(posedge clk) begin
    unique case (uc.act)
      fr_pkg::ACT_LOAD: begin
        if (in_ch.valid) begin
          a_r       <= nmag;
          b_r       <= dmag;
          n_r       <= nmag;
          d_r       <= dmag;
          neg_r     <= in_ch.numerator_in[M] ^ in_ch.denominator_in[M];
          special_r <= in_special;
          on_r      <= '0;
          od_r      <= '0;
          inv_r     <= in_special;
        end
      end
      fr_pkg::ACT_EUC_UPD: begin
        a_r <= b_r;
        b_r <= div_rem_r;
      end
      fr_pkg::ACT_UPD_N: begin
        n_r <= div_quo_r;
      end
      fr_pkg::ACT_UPD_D: begin
        d_r  <= div_quo_r;
        od_r <= div_quo_r;
        on_r <= neg_r ? -n_ext : n_ext;
      end
      default: begin
      end
    endcase
  end

  // Shared restoring divider, one quotient bit per cycle.
  always_comb begin
    div_start = 1'b1;
    div_dvd   = a_r;
    div_dvs   = b_r;
    unique case (uc.act)
      fr_pkg::ACT_START_AB: begin
        div_dvd = a_r;
        div_dvs = b_r;
      end
      fr_pkg::ACT_START_N: begin
        div_dvd = n_r;
        div_dvs = a_r;
      end
      fr_pkg::ACT_START_D: begin
        div_dvd = d_r;
        div_dvs = a_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign div_shl = {div_rem_r, div_quo_r[M-1]};
  assign div_ge  = (div_shl >= {1'b0, div_den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == CW'(1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem_r <= '0;
      div_quo_r <= div_dvd;
      div_den_r <= div_dvs;
      div_cnt_r <= CW'(M);
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? M'(div_shl - {1'b0, div_den_r}) : div_shl[M-1:0];
      div_quo_r <= {div_quo_r[M-2:0], div_ge};
      div_cnt_r <= div_cnt_r - CW'(1);
    end
  end

  `FR_ASSERT_NOW(a_one_in_flight, clk, rst_n, out_ch.valid, !in_ch.ready, "input taken while result pending")
  `FR_ASSERT_NOW(a_den_nonzero, clk, rst_n, out_ch.valid && !out_ch.invalid, out_ch.denominator_out != '0, "zero denominator on valid result")
  `FR_ASSERT_NOW(a_div_in_wait, clk, rst_n, div_busy_r, uc.act == fr_pkg::ACT_WAIT, "divider busy outside a wait step")
  `FR_ASSERT_NEXT(a_accept_check, clk, rst_n, in_ch.valid && in_ch.ready, step_r == fr_pkg::ST_CHECK, "sequencer skipped check after transfer")

endmodule
